// File: hdl/ldf_pkg.sv
// Shared types and constants of the length-prefixed frame deframer.
// Depends on nothing; every other file of the block but ldf_if imports it.
package ldf_pkg;

  localparam int unsigned LENGTH_DIGITS      = 8;
  localparam int unsigned NAME_LENGTH_DIGITS = 4;

  localparam int unsigned LEN_W  = 27;
  localparam int unsigned NAME_W = 14;

  localparam logic [LEN_W-1:0]  LEN_CAP  = {LEN_W{1'b1}};
  localparam logic [NAME_W-1:0] NAME_CAP = {NAME_W{1'b1}};

  // Result kinds.
  localparam logic [2:0] KIND_LINE_BYTE  = 3'd0;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd1;
  localparam logic [2:0] KIND_IMAGE_BYTE = 3'd2;
  localparam logic [2:0] KIND_EMPTY_LINE = 3'd3;
  localparam logic [2:0] KIND_BAD_LENGTH = 3'd4;

  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_BAR   = 8'h7C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       out_last;
  } ldf_result_t;

  // Expected header character at a given position of "LIN|" or "IMG|".
  function automatic logic [7:0] ldf_magic(input logic is_img, input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0: ch = is_img ? CHAR_I : CHAR_L;
      2'd1: ch = is_img ? CHAR_M : CHAR_I;
      2'd2: ch = is_img ? CHAR_G : CHAR_N;
      default: ch = CHAR_BAR;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/ldf_if.sv
// Valid/ready channel interfaces of the deframer: stream words in, results out.
// Depends on nothing.
interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output mode, output data_byte, output chunk_last,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input chunk_last,
                  output ready);
endinterface

interface ldf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input out_last,
                  output ready);
endinterface

// File: hdl/ldf_parser.sv
// Front part of the deframer: header, length and payload state machine.
// Depends on ldf_pkg; feeds results into the queue.
module ldf_parser
  import ldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_last_i,
  output logic        res_valid_o,
  output ldf_result_t res_o
);

  localparam logic [3:0] PH_WAIT      = 4'd0;
  localparam logic [3:0] PH_LIN_LEN   = 4'd1;
  localparam logic [3:0] PH_LIN_SEP   = 4'd2;
  localparam logic [3:0] PH_LIN_DATA  = 4'd3;
  localparam logic [3:0] PH_NAME_LEN  = 4'd4;
  localparam logic [3:0] PH_NAME_SEP  = 4'd5;
  localparam logic [3:0] PH_NAME_DATA = 4'd6;
  localparam logic [3:0] PH_NAME_END  = 4'd7;
  localparam logic [3:0] PH_IMG_LEN   = 4'd8;
  localparam logic [3:0] PH_IMG_SEP   = 4'd9;
  localparam logic [3:0] PH_IMG_DATA  = 4'd10;
  localparam logic [3:0] PH_DISCARD   = 4'd11;

  localparam logic [3:0] LEN_DIGITS_C  = 4'(LENGTH_DIGITS);
  localparam logic [3:0] NAME_DIGITS_C = 4'(NAME_LENGTH_DIGITS);

  logic [3:0]        phase_q, phase_d;
  logic [3:0]        pos_q, pos_d;
  logic              is_img_q, is_img_d;
  logic [LEN_W-1:0]  acc_q, acc_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [NAME_W-1:0] name_rem_q, name_rem_d;

  logic [7:0]        b;
  logic              is_digit;
  logic [LEN_W+3:0]  prod;
  logic [LEN_W-1:0]  acc_next;
  logic [3:0]        pos_inc;
  logic [3:0]        ndigits;
  logic              need_nonzero;
  logic [3:0]        digit_next_phase;

  assign b        = data_byte_i;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  // acc * 10 + digit, as two shifted copies and the digit value.
  assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {27'd0, b[3:0]};
  assign acc_next = (prod > {4'd0, LEN_CAP}) ? LEN_CAP : prod[LEN_W-1:0];
  assign pos_inc  = pos_q + 4'd1;

  always_comb begin
    unique case (phase_q)
      PH_NAME_LEN: begin
        ndigits = NAME_DIGITS_C; need_nonzero = 1'b1; digit_next_phase = PH_NAME_SEP;
      end
      PH_IMG_LEN: begin
        ndigits = LEN_DIGITS_C; need_nonzero = 1'b1; digit_next_phase = PH_IMG_SEP;
      end
      default: begin
        ndigits = LEN_DIGITS_C; need_nonzero = 1'b0; digit_next_phase = PH_LIN_SEP;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    is_img_d    = is_img_q;
    acc_d       = acc_q;
    remain_d    = remain_q;
    name_rem_d  = name_rem_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire_i) begin
      if (mode_i) begin
        phase_d    = PH_WAIT;
        pos_d      = '0;
        is_img_d   = 1'b0;
        acc_d      = '0;
        remain_d   = '0;
        name_rem_d = '0;
      end else begin
        unique case (phase_q)
          PH_LIN_LEN, PH_NAME_LEN, PH_IMG_LEN: begin
            if (!is_digit) begin
              phase_d     = chunk_last_i ? PH_WAIT : PH_DISCARD;
              pos_d       = '0;
              acc_d       = '0;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_BAD_LENGTH;
            end else begin
              acc_d = acc_next;
              pos_d = pos_inc;
              if (pos_inc >= ndigits) begin
                pos_d = '0;
                if (need_nonzero && (acc_next == '0)) begin
                  phase_d     = chunk_last_i ? PH_WAIT : PH_DISCARD;
                  acc_d       = '0;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_BAD_LENGTH;
                end else begin
                  phase_d = digit_next_phase;
                end
              end
            end
          end
          PH_LIN_SEP: begin
            remain_d = acc_q;
            acc_d    = '0;
            if (acc_q == '0) begin
              phase_d     = PH_WAIT;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_EMPTY_LINE;
            end else begin
              phase_d = PH_LIN_DATA;
            end
          end
          PH_LIN_DATA, PH_IMG_DATA: begin
            res_valid_o    = 1'b1;
            res_o.kind     = (phase_q == PH_IMG_DATA) ? KIND_IMAGE_BYTE : KIND_LINE_BYTE;
            res_o.out_byte = b;
            res_o.out_last = (remain_q <= LEN_W'(1));
            if (remain_q <= LEN_W'(1)) begin
              remain_d = '0;
              phase_d  = PH_WAIT;
            end else begin
              remain_d = remain_q - LEN_W'(1);
            end
          end
          PH_NAME_SEP: begin
            name_rem_d = (acc_q > {13'd0, NAME_CAP}) ? NAME_CAP : acc_q[NAME_W-1:0];
            acc_d      = '0;
            phase_d    = PH_NAME_DATA;
          end
          PH_NAME_DATA: begin
            res_valid_o    = 1'b1;
            res_o.kind     = KIND_NAME_BYTE;
            res_o.out_byte = b;
            res_o.out_last = (name_rem_q <= NAME_W'(1));
            if (name_rem_q <= NAME_W'(1)) begin
              name_rem_d = '0;
              phase_d    = PH_NAME_END;
            end else begin
              name_rem_d = name_rem_q - NAME_W'(1);
            end
          end
          PH_NAME_END: begin
            phase_d = PH_IMG_LEN;
          end
          PH_IMG_SEP: begin
            remain_d = acc_q;
            acc_d    = '0;
            phase_d  = PH_IMG_DATA;
          end
          PH_DISCARD: begin
            if (chunk_last_i) begin
              phase_d = PH_WAIT;
              pos_d   = '0;
            end
          end
          PH_WAIT: begin
            if (pos_q == 4'd0) begin
              if ((b == CHAR_L) || (b == CHAR_I)) begin
                is_img_d = (b == CHAR_I);
                pos_d    = 4'd1;
              end else begin
                phase_d = chunk_last_i ? PH_WAIT : PH_DISCARD;
                pos_d   = '0;
                acc_d   = '0;
              end
            end else if ((pos_q > 4'd3) || (ldf_magic(is_img_q, pos_q[1:0]) != b)) begin
              phase_d = chunk_last_i ? PH_WAIT : PH_DISCARD;
              pos_d   = '0;
              acc_d   = '0;
            end else if (pos_q == 4'd3) begin
              pos_d   = '0;
              acc_d   = '0;
              phase_d = is_img_q ? PH_NAME_LEN : PH_LIN_LEN;
            end else begin
              pos_d = pos_inc;
            end
          end
          default: begin
            phase_d = PH_WAIT;
            pos_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      pos_q      <= '0;
      is_img_q   <= 1'b0;
      acc_q      <= '0;
      remain_q   <= '0;
      name_rem_q <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      is_img_q   <= is_img_d;
      acc_q      <= acc_d;
      remain_q   <= remain_d;
      name_rem_q <= name_rem_d;
    end
  end

  // A data phase is only entered with a nonzero count still due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LIN_DATA || phase_q == PH_IMG_DATA) |-> (remain_q != '0))
    else $error("data phase with no bytes remaining");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NAME_DATA) |-> (name_rem_q != '0))
    else $error("filename phase with no bytes remaining");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && mode_i) |=> (phase_q == PH_WAIT && pos_q == 4'd0 && acc_q == '0))
    else $error("abort did not return the parser to header wait");

endmodule

// File: hdl/ldf_queue.sv
// Short result queue between the parser and the output stage.
// Depends on ldf_pkg for the result type.
module ldf_queue
  import ldf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ldf_result_t push_data_i,
  output logic        full_o,
  output logic        pop_valid_o,
  input  logic        pop_i,
  output ldf_result_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  ldf_result_t      slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign full_o      = (count_q == DEPTH_C);
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = slot_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DEPTH_C)
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into a full queue");

endmodule

// File: hdl/ldf_out_stage.sv
// Back part of the deframer: output register that drives the result channel.
// Depends on ldf_pkg and the ldf_out_if interface.
module ldf_out_stage
  import ldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  input  ldf_result_t pop_data_i,
  output logic        pop_o,
  ldf_out_if.source   out_o
);

  logic        valid_q, valid_d;
  ldf_result_t data_q;

  // The register reloads when the queue has a word and it is empty or its word is being taken.
  assign pop_o   = pop_valid_i && (!valid_q || out_o.ready);
  assign valid_d = pop_o ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= pop_data_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.kind     = data_q.kind;
  assign out_o.out_byte = data_q.out_byte;
  assign out_o.out_last = data_q.out_last;

endmodule

// File: hdl/length_prefixed_frame_deframer.sv
// Channel | Dir | Word fields                     | Accepted when
// in_i    | in  | mode, data_byte, chunk_last     | in_i.valid && in_i.ready
// out_o   | out | kind, out_byte, out_last        | out_o.valid && out_o.ready
//
// One stream word per cycle while in_i.ready is high, which drops only while the
// QUEUE_DEPTH-entry result queue is full. The parser updates state and counters
// in the cycle a word is accepted; results pass the queue, then output stage.
// Reset (rst_ni low, asynchronous) returns the parser to waiting for a header.
// Top level of the deframer; depends on ldf_pkg, ldf_if and the ldf_* modules.
module length_prefixed_frame_deframer
  import ldf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldf_in_if.sink    in_i,
  ldf_out_if.source out_o
);

  logic        fire;
  logic        full;
  logic        res_valid;
  ldf_result_t res;
  logic        pop_valid;
  logic        pop;
  ldf_result_t pop_data;

  assign in_i.ready = !full;
  assign fire       = in_i.valid && !full;

  ldf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .mode_i       (in_i.mode),
    .data_byte_i  (in_i.data_byte),
    .chunk_last_i (in_i.chunk_last),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ldf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  ldf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// File: verif/ldf_checker.sv
`timescale 1ns / 100ps
// Checker of the length-prefixed frame deframer: watches both channels, predicts each result
// from the accepted stream words and compares it field by field. Depends on ldf_pkg and ldf_if.
module ldf_checker
  import ldf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ldf_in_if    in_mon_i,
  ldf_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef enum logic [3:0] {
    PARSE_WAIT,
    PARSE_LIN_LEN,
    PARSE_LIN_SEP,
    PARSE_LIN_DATA,
    PARSE_NAME_LEN,
    PARSE_NAME_SEP,
    PARSE_NAME_DATA,
    PARSE_NAME_END,
    PARSE_IMG_LEN,
    PARSE_IMG_SEP,
    PARSE_IMG_DATA,
    PARSE_DISCARD
  } parse_phase_e;

  parse_phase_e      phase;
  logic [3:0]        field_pos;
  logic              in_image;
  logic [LEN_W-1:0]  length_sum;
  logic [LEN_W-1:0]  body_left;
  logic [NAME_W-1:0] name_left;
  ldf_result_t       expected_q[$];
  int                fails = 0;

  task automatic clear_parser();
    phase      = PARSE_WAIT;
    field_pos  = '0;
    in_image   = 1'b0;
    length_sum = '0;
    body_left  = '0;
    name_left  = '0;
  endtask

  task automatic queue_result(input logic [2:0] kind, input logic [7:0] b, input logic last);
    ldf_result_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.out_last = last;
    expected_q.push_back(r);
  endtask

  // Discarding ends at once when the offending word itself closes the chunk.
  task automatic begin_discard(input logic chunk_end);
    phase      = chunk_end ? PARSE_WAIT : PARSE_DISCARD;
    field_pos  = '0;
    length_sum = '0;
  endtask

  task automatic bad_length(input logic chunk_end);
    begin_discard(chunk_end);
    queue_result(KIND_BAD_LENGTH, 8'h00, 1'b0);
  endtask

  task automatic gather_digit(input logic [7:0] b, input logic chunk_end,
                              input int unsigned ndigits, input logic need_nonzero,
                              input parse_phase_e next);
    logic [31:0] sum;
    if (b < CHAR_ZERO || b > CHAR_NINE) begin
      bad_length(chunk_end);
      return;
    end
    sum = {5'd0, length_sum} * 32'd10 + {24'd0, b - CHAR_ZERO};
    length_sum = (sum > {5'd0, LEN_CAP}) ? LEN_CAP : sum[LEN_W-1:0];
    field_pos = field_pos + 4'd1;
    if (field_pos >= ndigits) begin
      field_pos = '0;
      // A zero filename or image length is only known on its last digit.
      if (need_nonzero && length_sum == '0) begin
        bad_length(chunk_end);
        return;
      end
      phase = next;
    end
  endtask

  task automatic deframe_word(input logic abort, input logic [7:0] b, input logic chunk_end);
    logic [7:0] want;
    logic [2:0] kind;
    logic       last;
    if (abort) begin
      clear_parser();
      return;
    end
    case (phase)
      PARSE_LIN_LEN: gather_digit(b, chunk_end, LENGTH_DIGITS, 1'b0, PARSE_LIN_SEP);
      PARSE_LIN_SEP: begin
        body_left  = length_sum;
        length_sum = '0;
        if (body_left == '0) begin
          phase = PARSE_WAIT;
          queue_result(KIND_EMPTY_LINE, 8'h00, 1'b0);
        end else begin
          phase = PARSE_LIN_DATA;
        end
      end
      PARSE_LIN_DATA, PARSE_IMG_DATA: begin
        kind = (phase == PARSE_LIN_DATA) ? KIND_LINE_BYTE : KIND_IMAGE_BYTE;
        last = (body_left <= 1);
        if (last) begin
          body_left = '0;
          phase     = PARSE_WAIT;
        end else begin
          body_left = body_left - 1'b1;
        end
        queue_result(kind, b, last);
      end
      PARSE_NAME_LEN: gather_digit(b, chunk_end, NAME_LENGTH_DIGITS, 1'b1, PARSE_NAME_SEP);
      PARSE_NAME_SEP: begin
        name_left  = (length_sum > NAME_CAP) ? NAME_CAP : length_sum[NAME_W-1:0];
        length_sum = '0;
        phase      = PARSE_NAME_DATA;
      end
      PARSE_NAME_DATA: begin
        last = (name_left <= 1);
        if (last) begin
          name_left = '0;
          phase     = PARSE_NAME_END;
        end else begin
          name_left = name_left - 1'b1;
        end
        queue_result(KIND_NAME_BYTE, b, last);
      end
      PARSE_NAME_END: phase = PARSE_IMG_LEN;
      PARSE_IMG_LEN: gather_digit(b, chunk_end, LENGTH_DIGITS, 1'b1, PARSE_IMG_SEP);
      PARSE_IMG_SEP: begin
        body_left  = length_sum;
        length_sum = '0;
        phase      = PARSE_IMG_DATA;
      end
      PARSE_DISCARD: begin
        if (chunk_end) begin
          phase     = PARSE_WAIT;
          field_pos = '0;
        end
      end
      PARSE_WAIT: begin
        if (field_pos == '0) begin
          if (b == CHAR_L || b == CHAR_I) begin
            in_image  = (b == CHAR_I);
            field_pos = 4'd1;
          end else begin
            begin_discard(chunk_end);
          end
        end else begin
          case (field_pos)
            4'd1:    want = in_image ? CHAR_M : CHAR_I;
            4'd2:    want = in_image ? CHAR_G : CHAR_N;
            default: want = CHAR_BAR;
          endcase
          if (field_pos > 4'd3 || b != want) begin
            begin_discard(chunk_end);
          end else begin
            field_pos = field_pos + 4'd1;
            if (field_pos == 4'd4) begin
              field_pos  = '0;
              length_sum = '0;
              phase      = in_image ? PARSE_NAME_LEN : PARSE_LIN_LEN;
            end
          end
        end
      end
      default: begin
        phase     = PARSE_WAIT;
        field_pos = '0;
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ldf_result_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Results pass the queue and the output register after their word is taken, so the
      // output is checked before the word of this edge is predicted.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result with none expected: kind %0d byte %0d last %0d", $time,
                   out_mon_i.kind, out_mon_i.out_byte, out_mon_i.out_last);
        end else begin
          want = expected_q.pop_front();
          check_field("kind", {5'd0, want.kind}, {5'd0, out_mon_i.kind});
          check_field("out_byte", want.out_byte, out_mon_i.out_byte);
          check_field("out_last", {7'd0, want.out_last}, {7'd0, out_mon_i.out_last});
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        deframe_word(in_mon_i.mode, in_mon_i.data_byte, in_mon_i.chunk_last);
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: verif/length_prefixed_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Testbench top of the length-prefixed frame deframer: clock, reset, stream stimulus and verdict.
// Depends on ldf_pkg, ldf_if, the deframer RTL and ldf_checker.
module length_prefixed_frame_deframer_tb;
  import ldf_pkg::*;

  localparam int unsigned WORD_TARGET  = 1850;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned PAYLOAD_CAP  = 24;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  int         fail_count;
  int         pending;
  int         words_sent = 0;
  int         send_quiet = 0;
  int         recv_quiet = 0;
  logic [7:0] frame_bytes[$];

  ldf_in_if  in_ch ();
  ldf_out_if out_ch ();

  length_prefixed_frame_deframer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  ldf_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle cycles before one word; now and then a stretch of words goes without any.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic random_chunk_end();
    return ($urandom_range(0, 7) == 0);
  endfunction

  task automatic send_word(input logic mode, input logic [7:0] b, input logic cl);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.data_byte  <= b;
    in_ch.chunk_last <= cl;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_abort();
    send_word(1'b1, 8'($urandom_range(0, 255)), random_chunk_end());
  endtask

  task automatic push_digits(input int unsigned value, input int unsigned ndigits);
    int unsigned scale;
    scale = 1;
    repeat (ndigits - 1) scale = scale * 10;
    repeat (ndigits) begin
      frame_bytes.push_back(CHAR_ZERO + 8'((value / scale) % 10));
      scale = scale / 10;
    end
  endtask

  // Fills frame_bytes with one frame; filename and payload are cut at cap bytes.
  task automatic build_frame(input logic is_img, input int unsigned name_len,
                             input int unsigned body_len, input int unsigned cap);
    frame_bytes.delete();
    if (is_img) begin
      frame_bytes.push_back(CHAR_I);
      frame_bytes.push_back(CHAR_M);
      frame_bytes.push_back(CHAR_G);
      frame_bytes.push_back(CHAR_BAR);
      push_digits(name_len, NAME_LENGTH_DIGITS);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ((name_len < cap) ? name_len : cap) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      frame_bytes.push_back(CHAR_L);
      frame_bytes.push_back(CHAR_I);
      frame_bytes.push_back(CHAR_N);
      frame_bytes.push_back(CHAR_BAR);
    end
    push_digits(body_len, LENGTH_DIGITS);
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    repeat ((body_len < cap) ? body_len : cap) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame_bytes(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(1'b0, frame_bytes[i], random_chunk_end());
    end
  endtask

  // Brings the parser back to waiting for a header, by abort or by a closing word.
  task automatic resync();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 1) begin
      send_abort();
    end else begin
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_L || b == CHAR_I);
      send_word(1'b0, b, 1'b1);
    end
  endtask

  initial begin
    int stall;
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    logic        is_img;
    logic        big;
    logic [7:0]  bad;
    int unsigned name_len;
    int unsigned body_len;
    int unsigned pick;
    int unsigned spot;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.chunk_last <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty line frame whose header is split across two chunks.
    build_frame(1'b0, 0, 0, 0);
    for (int unsigned i = 0; i < frame_bytes.size(); i++) begin
      send_word(1'b0, frame_bytes[i], (i == 2) || (i == frame_bytes.size() - 1));
    end
    // Unknown header byte that closes its own chunk, then an abort.
    send_word(1'b0, 8'h58, 1'b1);
    send_abort();
    // Magic that breaks off after two characters, discarded up to the chunk end.
    send_word(1'b0, CHAR_L, 1'b0);
    send_word(1'b0, CHAR_I, 1'b0);
    send_word(1'b0, 8'hFF, 1'b0);
    send_word(1'b0, 8'h00, 1'b1);
    // Non-digit in a filename length, on the last word of its chunk.
    send_word(1'b0, CHAR_I, 1'b0);
    send_word(1'b0, CHAR_M, 1'b0);
    send_word(1'b0, CHAR_G, 1'b0);
    send_word(1'b0, CHAR_BAR, 1'b0);
    send_word(1'b0, CHAR_ZERO, 1'b0);
    send_word(1'b0, 8'h78, 1'b1);

    while (words_sent < WORD_TARGET) begin
      pick   = $urandom_range(0, 99);
      is_img = 1'($urandom_range(0, 1));
      big    = ($urandom_range(0, 19) == 0);
      if (big) begin
        name_len = ($urandom_range(0, 1) == 1) ? 9999 : $urandom_range(1, 9999);
        body_len = ($urandom_range(0, 1) == 1) ? 99999999 : $urandom_range(25, 99999999);
      end else begin
        name_len = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 5);
        body_len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 16);
      end
      build_frame(is_img, name_len, body_len, PAYLOAD_CAP);
      if (big) begin
        // Long frame cut off by an abort while its counters are still large.
        send_frame_bytes(frame_bytes.size());
        send_abort();
      end else if (pick < 70) begin
        send_frame_bytes(frame_bytes.size());
        if (is_img && (name_len == 0 || body_len == 0)) resync();
      end else if (pick < 82) begin
        do bad = 8'($urandom_range(0, 255)); while (bad >= CHAR_ZERO && bad <= CHAR_NINE);
        spot = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[spot] = bad;
        send_frame_bytes(frame_bytes.size());
        resync();
      end else if (pick < 92) begin
        send_frame_bytes($urandom_range(0, frame_bytes.size() - 1));
        send_abort();
      end else begin
        repeat ($urandom_range(1, 5)) send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        resync();
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
